>>> rtl/core/rlrd_pkg.sv
// Shared types, constants and the ring pattern decode for the LED ring decoder.
`timescale 1ns / 1ps

package rlrd_pkg;

    localparam int NUM_TRACKS = 8;
    localparam int TRK_W      = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

    localparam int CTRL_W     = 7;
    localparam int RV_W       = 7;
    localparam int TPB_W      = 4;
    localparam int OFS_W      = 3;
    localparam int LED_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Restoring divide, one quotient bit per step
    localparam int DIV_STEPS  = CTRL_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TPB    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd3;

    localparam logic [CTRL_W-1:0] BASE_RST   = 7'd48;
    localparam logic [TPB_W-1:0]  TPB_RST    = 4'd1;
    localparam logic [OFS_W-1:0]  OFFSET_RST = 3'd0;
    localparam logic              CENTER_RST = 1'b1;

    localparam logic [3:0] POS_LIMIT = 4'hC;
    localparam logic [3:0] POS_CLAMP = 4'hB;
    localparam logic [3:0] RING_MID  = 4'd5;
    localparam logic [3:0] RING_LAST = 4'd10;

    localparam logic [1:0] MODE_DOT    = 2'd0;
    localparam logic [1:0] MODE_BAR    = 2'd1;
    localparam logic [1:0] MODE_FILL   = 2'd2;
    localparam logic [1:0] MODE_SPREAD = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic show;
    } rlrd_cmd_t;

    function automatic logic [LED_W-1:0] ring_pattern(input logic [RV_W-1:0] entry);
        logic [3:0]       pos;
        logic [3:0]       v;
        logic [3:0]       lo;
        logic [3:0]       hi;
        logic [LED_W-1:0] pat;
        pos = entry[3:0];
        if (pos > POS_CLAMP)
        begin
            pos = POS_CLAMP;
        end
        v = pos - 4'd1;
        unique case (entry[5:4])
            MODE_DOT:
            begin
                lo = v;
                hi = v;
            end
            MODE_BAR:
            begin
                lo = (v < RING_MID) ? v : RING_MID;
                hi = (v > RING_MID) ? v : RING_MID;
            end
            MODE_FILL:
            begin
                lo = 4'd0;
                hi = v;
            end
            MODE_SPREAD:
            begin
                lo = (v < RING_MID) ? (RING_MID - v) : 4'd0;
                hi = ((RING_MID + v) > RING_LAST) ? RING_LAST : (RING_MID + v);
            end
        endcase
        for (int i = 0; i < LED_W; i++)
        begin
            pat[i] = (4'(i) >= lo) && (4'(i) <= hi);
        end
        if (pos == 4'd0)
        begin
            pat = '0;
        end
        return pat;
    endfunction

endpackage

>>> rtl/core/rlrd_ctrl.sv
// Sequencer for the LED ring decoder: load, divide steps, store, show.
`timescale 1ns / 1ps

module rlrd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    output rlrd_pkg::rlrd_cmd_t cmd
);
    import rlrd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_SHOW
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                cmd.show   = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

>>> rtl/core/rlrd_dp.sv
// Datapath: config registers, serial divider, ring store and pattern decode.
`timescale 1ns / 1ps

module rlrd_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rlrd_pkg::rlrd_cmd_t               cmd,
    input  logic                              cfg_we,
    input  logic [rlrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlrd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [rlrd_pkg::CTRL_W-1:0]       controller,
    input  logic [rlrd_pkg::RV_W-1:0]         ring_value,
    output logic [rlrd_pkg::LED_W-1:0]        led_pattern,
    output logic                              center_led,
    output logic                              index_error
);
    import rlrd_pkg::*;

    logic [CTRL_W-1:0] base_reg;
    logic [TPB_W-1:0]  tpb_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic              center_en_reg;

    logic [CTRL_W-1:0] quo_reg;
    logic [CTRL_W-1:0] quo_next;
    logic [TPB_W-1:0]  rem_reg;
    logic [TPB_W-1:0]  rem_next;
    logic [TPB_W-1:0]  div_reg;
    logic              under_reg;
    logic [RV_W-1:0]   rv_reg;
    logic              err_reg;
    logic              err_next;

    logic [RV_W-1:0]   store_reg [NUM_TRACKS];
    logic [RV_W-1:0]   clamped;
    logic [RV_W-1:0]   shown;
    logic [7:0]        ofs_ext;
    logic [TPB_W:0]    trial;

    logic [LED_W-1:0]  led_reg;
    logic              center_reg;
    logic              ierr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RST;
            tpb_reg       <= TPB_RST;
            offset_reg    <= OFFSET_RST;
            center_en_reg <= CENTER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE:   base_reg      <= cfg_data[CTRL_W-1:0];
                CFG_TPB:    tpb_reg       <= cfg_data[TPB_W-1:0];
                CFG_OFFSET: offset_reg    <= cfg_data[OFS_W-1:0];
                CFG_CENTER: center_en_reg <= cfg_data[0];
            endcase
        end
    end

    // one restoring step: shift in dividend msb, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[CTRL_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = TPB_W'(trial - {1'b0, div_reg});
            quo_next = {quo_reg[CTRL_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[TPB_W-1:0];
            quo_next = {quo_reg[CTRL_W-2:0], 1'b0};
        end
    end

    assign err_next = under_reg || ({1'b0, quo_reg} >= 8'(NUM_TRACKS));

    always_comb
    begin
        clamped = rv_reg;
        if (rv_reg[3:0] >= POS_LIMIT)
        begin
            clamped[3:0] = POS_CLAMP;
        end
    end

    assign ofs_ext = 8'(offset_reg);
    assign shown   = (ofs_ext < 8'(NUM_TRACKS)) ? store_reg[ofs_ext[TRK_W-1:0]] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg   <= controller - base_reg;
            under_reg <= (controller < base_reg);
            div_reg   <= (tpb_reg == '0) ? TPB_W'(1) : tpb_reg;
            rem_reg   <= '0;
            rv_reg    <= ring_value;
        end
        else if (cmd.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.store)
        begin
            err_reg <= err_next;
        end
        if (cmd.show)
        begin
            led_reg    <= ring_pattern(shown);
            center_reg <= center_en_reg & shown[6];
            ierr_reg   <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TRACKS; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cmd.store && !err_next)
        begin
            store_reg[quo_reg[TRK_W-1:0]] <= clamped;
        end
    end

    assign led_pattern = led_reg;
    assign center_led  = center_reg;
    assign index_error = ierr_reg;

endmodule

>>> rtl/core/rotary_led_ring_decoder_core.sv
// Top level of the rotary LED ring decoder: sequencer plus datapath.
//
// channel  | signals                                    | transaction
// ---------+--------------------------------------------+-----------------------------
// command  | start, busy, controller, ring_value        | start & !busy
// result   | done, led_pattern, center_led, index_error | done, held one cycle
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | cfg_valid & cfg_ready
//
// The result strobe follows an accepted command after 7 divide steps (one quotient
// bit per cycle of the restoring divider), 1 store and 1 show; the core takes
// no new command until the result is strobed.
// A new command is taken in the cycle the result is strobed.
// Reset clears control state, config to defaults and the 8-entry ring store.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps

module rotary_led_ring_decoder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rlrd_pkg::CTRL_W-1:0]       controller,
    input  logic [rlrd_pkg::RV_W-1:0]         ring_value,
    output logic                              done,
    output logic [rlrd_pkg::LED_W-1:0]        led_pattern,
    output logic                              center_led,
    output logic                              index_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlrd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rlrd_pkg::*;

    rlrd_cmd_t cmd;

    assign cfg_ready = 1'b1;

    rlrd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rlrd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .controller  (controller),
        .ring_value  (ring_value),
        .led_pattern (led_pattern),
        .center_led  (center_led),
        .index_error (index_error)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a transaction in flight");

endmodule
